@@ src/serial_line_framer_utf8_core_defines.svh @@
// assertion macros used by the framer back end (slf_back)
// no dependencies
`ifndef SERIAL_LINE_FRAMER_UTF8_CORE_DEFINES_SVH
`define SERIAL_LINE_FRAMER_UTF8_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SLF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// next-cycle implication, disabled during reset
`define SLF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

@@ src/slf_pkg.sv @@
// shared types and constants of the serial line framer
// no dependencies
package slf_pkg;

    localparam int SLF_MAX_LINE = 512;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] UTF8_LEAD = 8'hC0;
    localparam logic [7:0] UTF8_CONT = 8'h80;
    localparam logic [7:0] UTF8_LOW_MASK = 8'h3F;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_EOL      = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    // work for one item; eol of KIND_DATA means no end marker
    typedef struct packed {
        logic       cr;
        logic       pay;
        logic [7:0] b;
        kind_t      eol;
    } pkt_t;

endpackage

@@ src/serial_line_framer_utf8_core.sv @@
// top level of the serial line framer with Latin-1 to UTF-8 re-encoding
// depends on slf_pkg, slf_front, slf_queue and slf_back
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | command, data_byte
//  out     | output    | out_valid / out_ready | kind, out_byte, last
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (terminator code)
//
// the front takes one item per cycle while the two-entry queue has room
// the back gives one result per cycle while out_ready is high, 1 to 4 results
// per item; it holds one item at a time in its output registers
// items that give no result never enter the queue
// reset clears line state and sets the terminator code to -1, no sweep
// cfg_ready is always high; out stalls back up through the queue to in_ready
module serial_line_framer_utf8_core #(
    parameter int MAX_LINE = slf_pkg::SLF_MAX_LINE
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [7:0]        data_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        kind,
    output logic [7:0]        out_byte,
    output logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic signed [8:0] cfg_data
);
    import slf_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    pkt_t push_pkt;
    pkt_t head_pkt;

    slf_front #(
        .MAX_LINE(MAX_LINE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .data_byte (data_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_pkt     (push_pkt)
    );

    slf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_pkt (push_pkt),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .head_pkt (head_pkt)
    );

    slf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head_pkt  (head_pkt),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

@@ src/slf_front.sv @@
// front end: accepts items, tracks line state, builds one work packet per item
// depends on slf_pkg
module slf_front #(
    parameter int MAX_LINE = slf_pkg::SLF_MAX_LINE
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              command,
    input  logic [7:0]        data_byte,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic signed [8:0] cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output slf_pkg::pkt_t     q_pkt
);
    import slf_pkg::*;

    localparam int LEN_W = $clog2(MAX_LINE + 1);

    logic [8:0]       term_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             hp_reg, hp_next;
    logic             held_reg, held_next;
    logic             custom;
    logic             is_term;
    logic             accept;
    pkt_t             pkt;

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign custom    = !term_reg[8];
    assign is_term   = custom ? (data_byte == term_reg[7:0])
                              : (data_byte == CHAR_CR || data_byte == CHAR_LF);

    always_comb
    begin
        len_next  = len_reg;
        hp_next   = hp_reg;
        held_next = held_reg;
        pkt       = '0;
        pkt.eol   = KIND_DATA;
        pkt.b     = data_byte;
        if (accept)
        begin
            if (command || is_term)
            begin
                pkt.eol   = hp_reg ? KIND_EOL : KIND_DATA;
                len_next  = '0;
                hp_next   = 1'b0;
                held_next = 1'b0;
            end
            else
            begin
                pkt.cr    = held_reg;
                hp_next   = hp_reg || held_reg;
                len_next  = len_reg + LEN_W'(1);
                if (custom && data_byte == CHAR_CR)
                begin
                    held_next = 1'b1;
                end
                else
                begin
                    held_next = 1'b0;
                    pkt.pay   = 1'b1;
                    hp_next   = 1'b1;
                end
                if (len_next == LEN_W'(MAX_LINE))
                begin
                    pkt.eol   = KIND_OVERFLOW;
                    len_next  = '0;
                    hp_next   = 1'b0;
                    held_next = 1'b0;
                end
            end
        end
    end

    assign q_pkt  = pkt;
    assign q_push = accept && (pkt.cr || pkt.pay || pkt.eol != KIND_DATA);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg <= 9'h1FF;
            len_reg  <= '0;
            hp_reg   <= 1'b0;
            held_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                term_reg <= cfg_data;
            end
            len_reg  <= len_next;
            hp_reg   <= hp_next;
            held_reg <= held_next;
        end
    end

endmodule

@@ src/slf_queue.sv @@
// two-entry packet queue between front and back
// depends on slf_pkg
module slf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  slf_pkg::pkt_t push_pkt,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output slf_pkg::pkt_t head_pkt
);
    import slf_pkg::*;

    pkt_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full     = cnt_reg == 2'd2;
    assign q_valid  = cnt_reg != 2'd0;
    assign head_pkt = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ src/slf_back.sv @@
// back end: expands a work packet into UTF-8 bytes and end markers
// depends on slf_pkg and serial_line_framer_utf8_core_defines.svh
`include "serial_line_framer_utf8_core_defines.svh"

module slf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  slf_pkg::pkt_t head_pkt,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    kind,
    output logic [7:0]    out_byte,
    output logic          last
);
    import slf_pkg::*;

    // slots: carriage return, first byte, second byte, end marker
    logic [3:0] mask_reg, mask_next;
    logic [7:0] b_reg;
    kind_t      eol_reg;
    logic [3:0] cur;
    logic [3:0] rest;
    logic       done;
    logic       load;
    kind_t      kind_sel;

    assign cur       = mask_reg & (~mask_reg + 4'd1);
    assign rest      = mask_reg & ~cur;
    assign out_valid = mask_reg != 4'd0;
    assign last      = rest == 4'd0;
    assign done      = out_valid && out_ready;
    assign load      = q_valid && (!out_valid || (done && last));
    assign q_pop     = load;

    always_comb
    begin
        kind_sel = KIND_DATA;
        out_byte = 8'h00;
        if (cur[0])
        begin
            out_byte = CHAR_CR;
        end
        else if (cur[1])
        begin
            out_byte = b_reg[7] ? (UTF8_LEAD | {6'd0, b_reg[7:6]}) : b_reg;
        end
        else if (cur[2])
        begin
            out_byte = UTF8_CONT | (b_reg & UTF8_LOW_MASK);
        end
        else if (cur[3])
        begin
            kind_sel = eol_reg;
        end
    end

    assign kind = kind_sel;

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = {head_pkt.eol != KIND_DATA, head_pkt.pay && head_pkt.b[7],
                         head_pkt.pay, head_pkt.cr};
        end
        else if (done)
        begin
            mask_next = rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b_reg   <= head_pkt.b;
            eol_reg <= head_pkt.eol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= 4'd0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    `SLF_ASSERT_IMP(a_marker_is_final, clk, rst_n, out_valid && kind != KIND_DATA, last)
    `SLF_ASSERT_NXT(a_item_continues, clk, rst_n, done && !last, out_valid)
    `SLF_ASSERT_NXT(a_drains_when_empty, clk, rst_n, done && last && !q_valid, !out_valid)

endmodule
